// ===== rtl/assert_macros.svh =====
// assertion macros for the ray box intersect block
// used by the top level only; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define RBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define RBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/rbs_pkg.sv =====
// shared widths, constants and types for the ray box slab intersect block
// no dependencies
package rbs_pkg;

    localparam int AXES     = 3;
    localparam int LANES    = 2 * AXES;
    localparam int FIX_W    = 32;
    localparam int SIZE_W   = 31;
    localparam int DIFF_W   = 35;
    localparam int MAG_W    = DIFF_W - 1;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = MAG_W + FRAC_W;
    localparam int DEN_W    = FIX_W;
    localparam int QMAG_W   = 28;
    localparam int QBITS    = QMAG_W - 1;
    localparam int DIV_LAT  = QBITS + 1;
    localparam int Q_W      = QMAG_W + 1;
    localparam int IDX_W    = 3;

    localparam int IN_W     = 6 * FIX_W;
    localparam int OUT_W    = 72;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTRE_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIZE_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIZE_Z   = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 31'd65536;

    // start values of the near and far distances (-1000.0 and +1000.0)
    localparam logic signed [Q_W-1:0] T_NEAR0 = -29'sd65536000;
    localparam logic signed [Q_W-1:0] T_FAR0  = 29'sd65536000;

    // one divider lane operand set
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_lane_in;

    // per axis flags that bypass the dividers
    typedef struct packed {
        logic dzero;
        logic outside;
    } t_axis_flags;

endpackage

// ===== rtl/rbs_front.sv =====
// front stage: box bounds, slab differences and divider operands per axis
// depends on rbs_pkg
module rbs_front (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [rbs_pkg::AXES*rbs_pkg::FIX_W-1:0]  i_centre,
    input  logic [rbs_pkg::AXES*rbs_pkg::SIZE_W-1:0] i_size,
    input  logic [rbs_pkg::AXES*rbs_pkg::FIX_W-1:0]  i_origin,
    input  logic [rbs_pkg::AXES*rbs_pkg::FIX_W-1:0]  i_dir,
    output rbs_pkg::t_lane_in                 o_lane [rbs_pkg::LANES],
    output rbs_pkg::t_axis_flags              o_flags [rbs_pkg::AXES]
);

    rbs_pkg::t_lane_in    r_lane [rbs_pkg::LANES];
    rbs_pkg::t_axis_flags r_flags [rbs_pkg::AXES];
    rbs_pkg::t_lane_in    n_lane [rbs_pkg::LANES];
    rbs_pkg::t_axis_flags n_flags [rbs_pkg::AXES];

    // bounds, differences and magnitudes for each axis
    always_comb begin
        logic signed [rbs_pkg::DIFF_W-1:0] c, h, o, lo, hi, d1, d2;
        logic [rbs_pkg::FIX_W-1:0]         d;
        logic [rbs_pkg::SIZE_W-1:0]        s;
        logic [rbs_pkg::MAG_W-1:0]         m1, m2;
        logic [rbs_pkg::DEN_W-1:0]         dm;
        for (int a = 0; a < rbs_pkg::AXES; a++) begin
            c  = rbs_pkg::DIFF_W'($signed(i_centre[a*rbs_pkg::FIX_W +: rbs_pkg::FIX_W]));
            o  = rbs_pkg::DIFF_W'($signed(i_origin[a*rbs_pkg::FIX_W +: rbs_pkg::FIX_W]));
            s  = i_size[a*rbs_pkg::SIZE_W +: rbs_pkg::SIZE_W];
            h  = $signed({5'd0, s[rbs_pkg::SIZE_W-1:1]});
            d  = i_dir[a*rbs_pkg::FIX_W +: rbs_pkg::FIX_W];
            lo = c - h;
            hi = c + h;
            d1 = lo - o;
            d2 = hi - o;
            m1 = d1[rbs_pkg::DIFF_W-1] ? rbs_pkg::MAG_W'(-d1) : rbs_pkg::MAG_W'(d1);
            m2 = d2[rbs_pkg::DIFF_W-1] ? rbs_pkg::MAG_W'(-d2) : rbs_pkg::MAG_W'(d2);
            dm = d[rbs_pkg::FIX_W-1] ? (~d + 1'b1) : d;
            n_lane[2*a].num   = {m1, 16'd0};
            n_lane[2*a].den   = dm;
            n_lane[2*a].neg   = d1[rbs_pkg::DIFF_W-1] ^ d[rbs_pkg::FIX_W-1];
            n_lane[2*a+1].num = {m2, 16'd0};
            n_lane[2*a+1].den = dm;
            n_lane[2*a+1].neg = d2[rbs_pkg::DIFF_W-1] ^ d[rbs_pkg::FIX_W-1];
            n_flags[a].dzero   = (d == '0);
            n_flags[a].outside = (o < lo) || (o > hi);
        end
    end

    // operand register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane  <= n_lane;
            r_flags <= n_flags;
        end
    end

    assign o_lane  = r_lane;
    assign o_flags = r_flags;

endmodule

// ===== rtl/rbs_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage, magnitude saturated
// depends on rbs_pkg
module rbs_div_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  rbs_pkg::t_lane_in            i_op,
    output logic [rbs_pkg::QMAG_W-1:0]   o_mag,
    output logic                         o_neg
);

    localparam int SUB_W = rbs_pkg::DEN_W + rbs_pkg::QMAG_W;

    logic [rbs_pkg::NUM_W-1:0]  r_rem [rbs_pkg::DIV_LAT];
    logic [rbs_pkg::DEN_W-1:0]  r_den [rbs_pkg::DIV_LAT];
    logic [rbs_pkg::QMAG_W-1:0] r_q   [rbs_pkg::DIV_LAT];
    logic                       r_neg [rbs_pkg::DIV_LAT];

    logic n_sat;

    // quotient at or beyond the saturation magnitude
    assign n_sat = {{(SUB_W-rbs_pkg::NUM_W){1'b0}}, i_op.num}
                   >= {1'b0, i_op.den, {rbs_pkg::QBITS{1'b0}}};

    // first stage: saturation check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_sat ? '0 : i_op.num;
            r_den[0] <= i_op.den;
            r_q[0]   <= n_sat ? {1'b1, {rbs_pkg::QBITS{1'b0}}} : '0;
            r_neg[0] <= i_op.neg;
        end
    end

    // one trial subtract per stage, msb first
    for (genvar i = 1; i < rbs_pkg::DIV_LAT; i++) begin : g_stage
        localparam int B = rbs_pkg::QBITS - i;
        logic [SUB_W:0] n_sub;
        assign n_sub = {{(SUB_W+1-rbs_pkg::NUM_W){1'b0}}, r_rem[i-1]}
                       - ({{(SUB_W+1-rbs_pkg::DEN_W){1'b0}}, r_den[i-1]} << B);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[i] <= r_den[i-1];
                r_neg[i] <= r_neg[i-1];
                if (!n_sub[SUB_W] && (r_den[i-1] != '0)) begin
                    r_rem[i]    <= n_sub[rbs_pkg::NUM_W-1:0];
                    r_q[i]      <= r_q[i-1] | (rbs_pkg::QMAG_W'(1) << B);
                end else begin
                    r_rem[i]    <= r_rem[i-1];
                    r_q[i]      <= r_q[i-1];
                end
            end
        end
    end

    assign o_mag = r_q[rbs_pkg::DIV_LAT-1];
    assign o_neg = r_neg[rbs_pkg::DIV_LAT-1];

endmodule

// ===== rtl/rbs_fold.sv =====
// back end: signed distances, per axis ordering, near/far fold and result beat
// depends on rbs_pkg
module rbs_fold (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rbs_pkg::QMAG_W-1:0]   i_mag [rbs_pkg::LANES],
    input  logic                         i_neg [rbs_pkg::LANES],
    input  rbs_pkg::t_axis_flags         i_flags [rbs_pkg::AXES],
    output logic                         o_hit,
    output logic [rbs_pkg::FIX_W-1:0]    o_t_near,
    output logic [rbs_pkg::FIX_W-1:0]    o_t_far
);

    logic signed [rbs_pkg::Q_W-1:0] r_lo [rbs_pkg::AXES];
    logic signed [rbs_pkg::Q_W-1:0] r_hi [rbs_pkg::AXES];
    logic                           r_miss1;
    logic signed [rbs_pkg::Q_W-1:0] r_near, r_far;
    logic                           r_miss2;
    logic                           r_hit;
    logic [rbs_pkg::FIX_W-1:0]      r_t_near, r_t_far;

    logic signed [rbs_pkg::Q_W-1:0] n_lo [rbs_pkg::AXES];
    logic signed [rbs_pkg::Q_W-1:0] n_hi [rbs_pkg::AXES];
    logic                           n_miss1;
    logic signed [rbs_pkg::Q_W-1:0] n_near, n_far;
    logic                           n_hit;

    // apply signs and order each axis pair; zero direction adds no limit
    always_comb begin
        logic signed [rbs_pkg::Q_W-1:0] q1, q2, m1, m2;
        n_miss1 = 1'b0;
        for (int a = 0; a < rbs_pkg::AXES; a++) begin
            m1 = $signed({1'b0, i_mag[2*a]});
            m2 = $signed({1'b0, i_mag[2*a+1]});
            q1 = i_neg[2*a]   ? -m1 : m1;
            q2 = i_neg[2*a+1] ? -m2 : m2;
            if (i_flags[a].dzero) begin
                n_lo[a] = rbs_pkg::T_NEAR0;
                n_hi[a] = rbs_pkg::T_FAR0;
                n_miss1 = n_miss1 | i_flags[a].outside;
            end else if (q1 > q2) begin
                n_lo[a] = q2;
                n_hi[a] = q1;
            end else begin
                n_lo[a] = q1;
                n_hi[a] = q2;
            end
        end
    end

    // fold all axes into near and far
    always_comb begin
        n_near = rbs_pkg::T_NEAR0;
        n_far  = rbs_pkg::T_FAR0;
        for (int a = 0; a < rbs_pkg::AXES; a++) begin
            if (r_lo[a] > n_near) n_near = r_lo[a];
            if (r_hi[a] < n_far)  n_far  = r_hi[a];
        end
    end

    assign n_hit = !r_miss2 && (r_near <= r_far) && !r_far[rbs_pkg::Q_W-1];

    // stage registers and result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_miss1  <= n_miss1;
            r_near   <= n_near;
            r_far    <= n_far;
            r_miss2  <= r_miss1;
            r_hit    <= n_hit;
            r_t_near <= n_hit ? rbs_pkg::FIX_W'(r_near) : '0;
            r_t_far  <= n_hit ? rbs_pkg::FIX_W'(r_far)  : '0;
        end
    end

    assign o_hit    = r_hit;
    assign o_t_near = r_t_near;
    assign o_t_far  = r_t_far;

endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// Ray against axis-aligned box by the slab method. One ray is taken per clock
// while no result is stalled, and every ray gives one result beat through 32
// register stages: the bound and difference setup register (loaded at the
// taking edge), 28 stages in the six parallel divider lanes (one quotient bit
// per stage), two stages of ordering and near/far folding, and the output
// register. The whole pipeline holds while a result waits on i_m_tready, so
// nothing is dropped or repeated. The user must write box registers through
// the plain write port only while no ray is in flight; this is not enforced.
// depends on rbs_pkg, rbs_front, rbs_div_lane, rbs_fold, assert_macros.svh
`include "assert_macros.svh"

module ray_box_slab_intersect (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [rbs_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // hit, t_near, t_far, zero pad
    output logic [rbs_pkg::OUT_W-1:0]   o_m_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        i_cfg_we,
    input  logic [rbs_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rbs_pkg::FIX_W-1:0]   i_cfg_data
);

    localparam int VLD_LEN = rbs_pkg::DIV_LAT + 4;
    localparam int AF      = rbs_pkg::AXES * rbs_pkg::FIX_W;

    logic [AF-1:0]                              r_centre;
    logic [rbs_pkg::AXES*rbs_pkg::SIZE_W-1:0]   r_size;
    logic [VLD_LEN-1:0]                         r_vld;
    rbs_pkg::t_axis_flags                       r_flags [rbs_pkg::DIV_LAT][rbs_pkg::AXES];

    logic                        w_en;
    rbs_pkg::t_lane_in           w_lane  [rbs_pkg::LANES];
    rbs_pkg::t_axis_flags        w_flags [rbs_pkg::AXES];
    logic [rbs_pkg::QMAG_W-1:0]  w_mag   [rbs_pkg::LANES];
    logic                        w_neg   [rbs_pkg::LANES];
    logic                        w_hit;
    logic [rbs_pkg::FIX_W-1:0]   w_t_near, w_t_far;

    assign w_en       = !r_vld[VLD_LEN-1] || i_m_tready;
    assign o_s_tready = w_en;

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= '0;
            r_size   <= {rbs_pkg::SIZE_RESET, rbs_pkg::SIZE_RESET, rbs_pkg::SIZE_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbs_pkg::REG_CENTRE_X: r_centre[0*32 +: 32] <= i_cfg_data;
                rbs_pkg::REG_CENTRE_Y: r_centre[1*32 +: 32] <= i_cfg_data;
                rbs_pkg::REG_CENTRE_Z: r_centre[2*32 +: 32] <= i_cfg_data;
                rbs_pkg::REG_SIZE_X:   r_size[0*31 +: 31]   <= i_cfg_data[30:0];
                rbs_pkg::REG_SIZE_Y:   r_size[1*31 +: 31]   <= i_cfg_data[30:0];
                rbs_pkg::REG_SIZE_Z:   r_size[2*31 +: 31]   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_LEN-2:0], i_s_tvalid};
        end
    end

    rbs_front u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_centre (r_centre),
        .i_size   (r_size),
        .i_origin (i_s_tdata[AF-1:0]),
        .i_dir    (i_s_tdata[2*AF-1:AF]),
        .o_lane   (w_lane),
        .o_flags  (w_flags)
    );

    // six divider lanes: entry and exit per axis
    for (genvar l = 0; l < rbs_pkg::LANES; l++) begin : g_lane
        rbs_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (w_lane[l]),
            .o_mag (w_mag[l]),
            .o_neg (w_neg[l])
        );
    end

    // axis flags ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flags[0] <= w_flags;
            for (int i = 1; i < rbs_pkg::DIV_LAT; i++) r_flags[i] <= r_flags[i-1];
        end
    end

    rbs_fold u_fold (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_mag    (w_mag),
        .i_neg    (w_neg),
        .i_flags  (r_flags[rbs_pkg::DIV_LAT-1]),
        .o_hit    (w_hit),
        .o_t_near (w_t_near),
        .o_t_far  (w_t_far)
    );

    assign o_m_tvalid = r_vld[VLD_LEN-1];
    assign o_m_tdata  = {7'd0, w_t_far, w_t_near, w_hit};

    // a miss carries zero distances
    `RBS_ASSERT(a_miss_zero, o_m_tvalid && !w_hit |-> (w_t_near == '0) && (w_t_far == '0), "miss with nonzero distance")
    // a hit lies ahead of the origin and in order
    `RBS_ASSERT(a_hit_order, o_m_tvalid && w_hit |-> ($signed(w_t_near) <= $signed(w_t_far)) && !w_t_far[31], "hit distances out of order")
    // a held result stays put while the pipeline is frozen
    `RBS_ASSERT(a_freeze, !w_en |=> $stable(r_vld) && $stable(w_hit), "pipeline moved during stall")
    // reset empties the pipeline
    `RBS_ASSERT_ALWAYS(a_reset, !i_rst_n |=> (r_vld == '0), "valid bits survive reset")

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for ray_box_slab_intersect: rays in, hit/near/far out
// depends on rbs_pkg and the ray_box_slab_intersect top level
module tb_top;

    localparam int LATENCY = 32;
    localparam longint T_NEAR_START = -64'sd65536000;
    localparam longint T_FAR_START  = 64'sd65536000;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic        hit;
        logic [31:0] t_near;
        logic [31:0] t_far;
    } box_hit_t;

    typedef struct {
        logic [31:0] org [3];
        logic [31:0] dir [3];
        logic        known;
        box_hit_t    hit_val;
    } ray_row_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic [rbs_pkg::IN_W-1:0]      i_s_tdata = '0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [rbs_pkg::OUT_W-1:0]     o_m_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [rbs_pkg::IDX_W-1:0]     i_cfg_idx = '0;
    logic [rbs_pkg::FIX_W-1:0]     i_cfg_data = '0;

    // shadow copy of the box registers
    logic [31:0] box_centre [3];
    logic [30:0] box_size [3];

    box_hit_t hit_queue [$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    ray_box_slab_intersect u_top (.*);

    always #4 i_clk = ~i_clk;

    // slab predictor for one ray against the shadow box
    function automatic box_hit_t slab_intersect(input logic [31:0] org [3],
                                                input logic [31:0] dir [3]);
        longint near_t, far_t, c, half, lo, hi, o, d, q1, q2, t;
        logic   in_slab;
        box_hit_t r;
        near_t  = T_NEAR_START;
        far_t   = T_FAR_START;
        in_slab = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (in_slab) begin
                c    = longint'(signed'(box_centre[a]));
                half = longint'({33'd0, box_size[a]}) >>> 1;
                lo   = c - half;
                hi   = c + half;
                o    = longint'(signed'(org[a]));
                d    = longint'(signed'(dir[a]));
                if (d == 0) begin
                    if (o < lo || o > hi) in_slab = 1'b0;
                end else begin
                    q1 = ((lo - o) * 65536) / d;
                    q2 = ((hi - o) * 65536) / d;
                    if (q1 > q2) begin
                        t = q1; q1 = q2; q2 = t;
                    end
                    if (q1 > near_t) near_t = q1;
                    if (q2 < far_t) far_t = q2;
                    if (near_t > far_t || far_t < 0) in_slab = 1'b0;
                end
            end
        end
        r.hit    = in_slab;
        r.t_near = in_slab ? near_t[31:0] : 32'd0;
        r.t_far  = in_slab ? far_t[31:0] : 32'd0;
        return r;
    endfunction

    // register write, block idle
    task automatic write_box_reg(input logic [rbs_pkg::IDX_W-1:0] idx,
                                 input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            rbs_pkg::REG_CENTRE_X: box_centre[0] = val;
            rbs_pkg::REG_CENTRE_Y: box_centre[1] = val;
            rbs_pkg::REG_CENTRE_Z: box_centre[2] = val;
            rbs_pkg::REG_SIZE_X:   box_size[0] = val[30:0];
            rbs_pkg::REG_SIZE_Y:   box_size[1] = val[30:0];
            rbs_pkg::REG_SIZE_Z:   box_size[2] = val[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // send one ray beat, random idle before it; valid stays up for the next beat
    task automatic send_ray(input ray_row_t row);
        box_hit_t exp_val;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        exp_val = slab_intersect(row.org, row.dir);
        if (row.known && exp_val !== row.hit_val) begin
            $error("table row: expected %h actual %h", row.hit_val, exp_val);
            errors++;
        end
        i_s_tdata  <= {row.dir[2], row.dir[1], row.dir[0],
                       row.org[2], row.org[1], row.org[0]};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        hit_queue.push_back(exp_val);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom_range(3);
            2: return 32'h7fff_fffc | $urandom_range(3);
            3: return 32'd0;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic random_rays(input int count);
        ray_row_t row;
        for (int n = 0; n < count; n++) begin
            for (int a = 0; a < 3; a++) begin
                row.org[a] = rand_coord();
                row.dir[a] = ($urandom_range(7) == 0) ? 32'd0 : rand_coord();
            end
            // aim most rays at the box centre
            if ($urandom_range(3) != 0)
                for (int a = 0; a < 3; a++)
                    if (row.dir[a] != 0)
                        row.dir[a] = box_centre[a] - row.org[a] + ($urandom_range(15) - 8);
            row.known = 1'b0;
            send_ray(row);
        end
        i_s_tvalid <= 1'b0;
    endtask

    // receiver: random stall, checks each result beat
    always @(negedge i_clk) begin
        if (i_rst_n) i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        box_hit_t got, exp_val;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.hit    = o_m_tdata[0];
            got.t_near = o_m_tdata[32:1];
            got.t_far  = o_m_tdata[64:33];
            if (hit_queue.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_val = hit_queue.pop_front();
                if (got.hit !== exp_val.hit) begin
                    $error("hit: expected %0d actual %0d", exp_val.hit, got.hit); errors++;
                end
                if (got.t_near !== exp_val.t_near) begin
                    $error("t_near: expected %h actual %h", exp_val.t_near, got.t_near);
                    errors++;
                end
                if (got.t_far !== exp_val.t_far) begin
                    $error("t_far: expected %h actual %h", exp_val.t_far, got.t_far);
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // directed rays for the unit box at the origin
    ray_row_t dir_table [$];
    function automatic ray_row_t mk(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                    input logic known, input box_hit_t v);
        ray_row_t r;
        r.org = '{ox, oy, oz};
        r.dir = '{dx, dy, dz};
        r.known = known;
        r.hit_val = v;
        return r;
    endfunction

    initial begin
        ray_row_t row;
        box_centre = '{32'd0, 32'd0, 32'd0};
        box_size   = '{31'd65536, 31'd65536, 31'd65536};
        // on the surface with zero direction: inside, untouched near/far
        dir_table.push_back(mk(32'h0000_8000, 0, 0, 0, 0, 0, 1,
                               {1'b1, 32'hfc18_0000, 32'h03e8_0000}));
        dir_table.push_back(mk(32'hffff_8000, 32'h0000_8000, 32'hffff_8000, 0, 0, 0, 1,
                               {1'b1, 32'hfc18_0000, 32'h03e8_0000}));
        // zero direction outside the slab: miss
        dir_table.push_back(mk(32'h0000_8001, 0, 0, 0, 0, 0, 1, '0));
        dir_table.push_back(mk(0, 0, 32'h8000_0000, 0, 0, 0, 1, '0));
        // unit ray from -2 along x: near 1.5, far 2.5
        dir_table.push_back(mk(32'hfffe_0000, 0, 0, 32'h0001_0000, 0, 0, 1,
                               {1'b1, 32'h0001_8000, 32'h0002_8000}));
        // pointing away: miss
        dir_table.push_back(mk(32'hfffe_0000, 0, 0, 32'hffff_0000, 0, 0, 1, '0));
        // extremes of the fields
        dir_table.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 1, 0, 0, '0));
        dir_table.push_back(mk(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, '0));
        dir_table.push_back(mk(0, 0, 0, 1, 1, 1, 0, '0));
        dir_table.push_back(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0));
        dir_table.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0));
        dir_table.push_back(mk(0, 32'hfffe_0000, 0, 0, 32'h0000_0001, 0, 0, '0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k]) send_ray(dir_table[k]);
        i_s_tvalid <= 1'b0;
        wait_drained();

        // sweep idle phases under several box settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            case (ph)
                1: begin
                    write_box_reg(rbs_pkg::REG_CENTRE_X, 32'h7fff_ffff);
                    write_box_reg(rbs_pkg::REG_CENTRE_Y, 32'h8000_0000);
                    write_box_reg(rbs_pkg::REG_CENTRE_Z, 32'h0001_0000);
                    write_box_reg(rbs_pkg::REG_SIZE_X, 32'hffff_ffff);
                    write_box_reg(rbs_pkg::REG_SIZE_Y, 32'h7fff_ffff);
                    write_box_reg(rbs_pkg::REG_SIZE_Z, 32'd0);
                end
                3: begin
                    write_box_reg(rbs_pkg::REG_SIZE_X, 32'd0);
                    write_box_reg(rbs_pkg::REG_SIZE_Y, 32'd1);
                    write_box_reg(rbs_pkg::REG_SIZE_Z, 32'h8001_0000);
                    write_box_reg(3'd7, 32'hdead_beef);
                    write_box_reg(3'd6, 32'h1234_5678);
                end
                default: if (ph > 1) for (int r = 0; r < 6; r++)
                    write_box_reg(rbs_pkg::IDX_W'(r), r < 3 ? rand_coord()
                                                   : $urandom_range(32'h0010_0000));
            endcase
            random_rays(90);
            // sender holds off until the pipe is empty
            if (ph == 4) while (hit_queue.size() != 0) @(negedge i_clk);
            wait_drained();
        end

        if (errors == 0 && hit_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_front.sv
rtl/rbs_div_lane.sv
rtl/rbs_fold.sv
rtl/ray_box_slab_intersect.sv
dv/tb_top.sv
